// ===== hw/rtl/tts_pkg.sv =====
// Package for the template tag scanner: position width, mark tables,
// scan phase type and the state and result structs.
// No dependencies.
`default_nettype none

package tts_pkg;

	localparam int POS_BITS = 16;
	localparam int FIELD_BITS = 16;
	localparam int KIND_BITS = 3;
	localparam int NUM_KINDS = 8;

	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	localparam logic [7:0] BRACE_OPEN = 8'h7B;
	localparam logic [7:0] BRACE_CLOSE = 8'h7D;
	localparam logic [7:0] TERMINATOR = 8'h00;

	// Marks after the opening brace, in kind order: { _ % ( ^ < - *
	localparam logic [7:0] OPEN_MARK [NUM_KINDS] = '{
		8'h7B, 8'h5F, 8'h25, 8'h28, 8'h5E, 8'h3C, 8'h2D, 8'h2A
	};
	// Marks before the closing brace: } _ % ) ^ > - *
	localparam logic [7:0] CLOSE_MARK [NUM_KINDS] = '{
		8'h7D, 8'h5F, 8'h25, 8'h29, 8'h5E, 8'h3E, 8'h2D, 8'h2A
	};

	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_BRACE  = 2'd1,
		PH_INSIDE = 2'd2,
		PH_CLOSE1 = 2'd3
	} tts_phase_t;

	typedef struct packed {
		logic [POS_BITS-1:0]  position;
		logic [POS_BITS-1:0]  run_start;
		logic [POS_BITS-1:0]  open_at;
		tts_phase_t           phase;
		logic [KIND_BITS-1:0] kind;
		logic                 stopped;
	} tts_state_t;

	typedef struct packed {
		logic                   emit;
		logic                   found;
		logic                   done_res;
		logic [FIELD_BITS-1:0]  text_start;
		logic [FIELD_BITS-1:0]  tag_start;
		logic [FIELD_BITS-1:0]  tag_end;
		logic [KIND_BITS-1:0]   tag_kind;
	} tts_result_t;

	localparam tts_state_t STATE_RESET = '{
		position:  '0,
		run_start: '0,
		open_at:   '0,
		phase:     PH_SEARCH,
		kind:      '0,
		stopped:   1'b0
	};

	function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
		return (v == POS_MAX) ? v : v + POS_BITS'(1);
	endfunction

	// Low field bits of a position, zero-extended when positions are narrower
	function automatic logic [FIELD_BITS-1:0] pos_field(input logic [POS_BITS-1:0] p);
		logic [31:0] w;
		w = 32'(p);
		return w[FIELD_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tts_if.sv =====
// Channel interfaces for the template tag scanner: text bytes in, tag results out.
// Depends on tts_pkg.
`default_nettype none

interface tts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last_byte;

	modport source (output valid, text_byte, last_byte, input ready);
	modport sink (input valid, text_byte, last_byte, output ready);
endinterface

interface tts_out_if;
	logic                             valid;
	logic                             ready;
	logic                             found;
	logic                             done_res;
	logic [tts_pkg::FIELD_BITS-1:0]   text_start;
	logic [tts_pkg::FIELD_BITS-1:0]   tag_start;
	logic [tts_pkg::FIELD_BITS-1:0]   tag_end;
	logic [tts_pkg::KIND_BITS-1:0]    tag_kind;

	modport source (output valid, found, done_res, text_start, tag_start, tag_end,
		tag_kind, input ready);
	modport sink (input valid, found, done_res, text_start, tag_start, tag_end,
		tag_kind, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tts_step.sv =====
// Next-state and result logic of the scanner for one text byte.
// Depends on tts_pkg.
`default_nettype none

module tts_step (
	input  wire tts_pkg::tts_state_t  cur,
	input  wire logic [7:0]           text_byte,
	input  wire logic                 last_byte,
	output tts_pkg::tts_state_t       nxt,
	output tts_pkg::tts_result_t      res
);

	logic                          mark_hit;
	logic [tts_pkg::KIND_BITS-1:0] mark_kind;
	logic                          hit;

	always_comb begin
		mark_hit = 1'b0;
		mark_kind = '0;
		for (int k = 0; k < tts_pkg::NUM_KINDS; k++) begin
			if (!mark_hit && text_byte == tts_pkg::OPEN_MARK[k]) begin
				mark_hit = 1'b1;
				mark_kind = tts_pkg::KIND_BITS'(k);
			end
		end
	end

	always_comb begin
		nxt = cur;
		hit = 1'b0;
		nxt.position = tts_pkg::sat_inc(cur.position);
		if (!cur.stopped) begin
			if (text_byte == tts_pkg::TERMINATOR) begin
				nxt.stopped = 1'b1;
			end else begin
				case (cur.phase)
					tts_pkg::PH_SEARCH: begin
						if (text_byte == tts_pkg::BRACE_OPEN) begin
							nxt.open_at = cur.position;
							nxt.phase = tts_pkg::PH_BRACE;
						end
					end
					tts_pkg::PH_BRACE: begin
						if (mark_hit) begin
							nxt.kind = mark_kind;
							nxt.phase = tts_pkg::PH_INSIDE;
						end else begin
							nxt.phase = tts_pkg::PH_SEARCH;
						end
					end
					default: begin
						// a failed closing pair rechecks this byte as a first closing byte
						if (cur.phase == tts_pkg::PH_CLOSE1
								&& text_byte == tts_pkg::BRACE_CLOSE) begin
							hit = 1'b1;
							nxt.run_start = tts_pkg::sat_inc(cur.position);
							nxt.phase = tts_pkg::PH_SEARCH;
						end else if (text_byte == tts_pkg::CLOSE_MARK[cur.kind]) begin
							nxt.phase = tts_pkg::PH_CLOSE1;
						end else begin
							nxt.phase = tts_pkg::PH_INSIDE;
						end
					end
				endcase
			end
		end
		if (last_byte) begin
			nxt = tts_pkg::STATE_RESET;
		end
	end

	always_comb begin
		res.emit = hit || last_byte;
		res.found = hit;
		res.done_res = last_byte;
		res.text_start = hit ? tts_pkg::pos_field(cur.run_start) : '0;
		res.tag_start = hit ? tts_pkg::pos_field(cur.open_at) : '0;
		res.tag_end = hit ? tts_pkg::pos_field(cur.position) : '0;
		res.tag_kind = hit ? cur.kind : '0;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/template_tag_scanner.sv =====
// Top level of the template tag scanner: input register, scan step, result register.
// Depends on tts_pkg, tts_if (tts_in_if, tts_out_if) and tts_step.
//
//   channel   dir  payload                                               transaction
//   text_in   in   text_byte[7:0], last_byte                              one byte
//   tag_out   out  found, done_res, text_start, tag_start, tag_end, kind  0 or 1 per byte
//
// One byte per cycle while the result register is not stalled; a result passes through the
// input register, then the single scan step, into the result register.
// arst_n clears the valid flags and the scan state to the start of a text.
// A stalled result holds the input register; text_in stays ready while the input
// register is empty or moving on.
`default_nettype none

module template_tag_scanner (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tts_in_if.sink     text_in,
	tts_out_if.source  tag_out
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	logic                 advance;
	tts_pkg::tts_state_t  state_q;
	tts_pkg::tts_state_t  state_nxt;
	tts_pkg::tts_result_t res;
	tts_pkg::tts_result_t res_q;
	logic                 out_valid_q;

	assign advance = valid_s1 && (!out_valid_q || tag_out.ready);
	assign text_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.ready && text_in.valid) begin
			byte_s1 <= text_in.text_byte;
			last_s1 <= text_in.last_byte;
		end
	end

	tts_step u_step (
		.cur       (state_q),
		.text_byte (byte_s1),
		.last_byte (last_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tts_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.emit;
		end else if (tag_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			res_q <= res;
		end
	end

	assign tag_out.valid = out_valid_q;
	assign tag_out.found = res_q.found;
	assign tag_out.done_res = res_q.done_res;
	assign tag_out.text_start = res_q.text_start;
	assign tag_out.tag_start = res_q.tag_start;
	assign tag_out.tag_end = res_q.tag_end;
	assign tag_out.tag_kind = res_q.tag_kind;

	// a result that does not end the text must report a tag
	a_result_has_reason: assert property (@(posedge clk) disable iff (!arst_n)
		tag_out.valid |-> (tag_out.found || tag_out.done_res))
		else $error("result with neither found nor done");

	// a done result without a tag carries zero fields
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_out.valid && !tag_out.found) |->
			(tag_out.text_start == '0 && tag_out.tag_start == '0
			&& tag_out.tag_end == '0 && tag_out.tag_kind == '0))
		else $error("done result without tag has non-zero fields");

	// a tag only closes from the first-closing-byte phase
	a_hit_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.found) |-> (state_q.phase == tts_pkg::PH_CLOSE1))
		else $error("tag closed outside closing phase");

	// the terminator holds until the last byte of the text
	a_stop_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q.stopped && !last_s1) |=> state_q.stopped)
		else $error("stopped flag cleared before last byte");

	// the last byte returns the scan to the start state
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (state_q.position == '0
			&& state_q.phase == tts_pkg::PH_SEARCH && !state_q.stopped))
		else $error("state not cleared after last byte");

endmodule

`default_nettype wire

// ===== tb/template_tag_scanner_test.sv =====
// Self-checking bench for template_tag_scanner: directed and random byte streams with tags.
// Predicts each tag and end-of-text result from its own scan state and compares in order.
// Depends on tts_pkg, tts_if and the template_tag_scanner RTL.

module template_tag_scanner_test;

	localparam int CLK_HALF = 2;
	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 225;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} text_item_t;

	typedef struct packed {
		logic                           found;
		logic                           done_res;
		logic [tts_pkg::FIELD_BITS-1:0] text_start;
		logic [tts_pkg::FIELD_BITS-1:0] tag_start;
		logic [tts_pkg::FIELD_BITS-1:0] tag_end;
		logic [tts_pkg::KIND_BITS-1:0]  tag_kind;
	} tag_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       in_valid = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_ready = 1'b0;

	tts_in_if  text_in ();
	tts_out_if tag_out ();

	assign text_in.valid = in_valid;
	assign text_in.text_byte = in_byte;
	assign text_in.last_byte = in_last;
	assign tag_out.ready = out_ready;

	template_tag_scanner uut (
		.clk(clk),
		.arst_n(arst_n),
		.text_in(text_in),
		.tag_out(tag_out)
	);

	text_item_t  text_q[$];
	tag_report_t tag_reports_q[$];
	text_item_t  next_item;
	tag_report_t got_report;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit recv_hold = 1'b0;
	bit hold_go = 1'b0;
	int errors = 0;
	int phase_items = 0;

	// scan state of the predictor
	logic [tts_pkg::POS_BITS-1:0]  scan_pos = '0;
	logic [tts_pkg::POS_BITS-1:0]  run_from = '0;
	logic [tts_pkg::POS_BITS-1:0]  brace_at = '0;
	tts_pkg::tts_phase_t           scan_ph = tts_pkg::PH_SEARCH;
	logic [tts_pkg::KIND_BITS-1:0] held_kind = '0;
	bit                            halted = 1'b0;

	task automatic clear_scan_state();
		scan_pos = '0;
		run_from = '0;
		brace_at = '0;
		scan_ph = tts_pkg::PH_SEARCH;
		held_kind = '0;
		halted = 1'b0;
	endtask

	function automatic logic [tts_pkg::POS_BITS-1:0] pos_step(
			input logic [tts_pkg::POS_BITS-1:0] p);
		return (p == {tts_pkg::POS_BITS{1'b1}}) ? p : p + tts_pkg::POS_BITS'(1);
	endfunction

	task automatic predict_scan(input logic [7:0] b, input logic last);
		logic [tts_pkg::POS_BITS-1:0] cur;
		tag_report_t                  rep;
		bit                           hit;
		bit                           matched;
		cur = scan_pos;
		rep = '0;
		hit = 1'b0;
		matched = 1'b0;
		scan_pos = pos_step(cur);
		if (!halted) begin
			if (b == tts_pkg::TERMINATOR) begin
				halted = 1'b1;
			end else begin
				case (scan_ph)
					tts_pkg::PH_SEARCH: begin
						if (b == tts_pkg::BRACE_OPEN) begin
							brace_at = cur;
							scan_ph = tts_pkg::PH_BRACE;
						end
					end
					tts_pkg::PH_BRACE: begin
						scan_ph = tts_pkg::PH_SEARCH;
						for (int k = 0; k < tts_pkg::NUM_KINDS; k++) begin
							if (!matched && b == tts_pkg::OPEN_MARK[k]) begin
								held_kind = tts_pkg::KIND_BITS'(k);
								scan_ph = tts_pkg::PH_INSIDE;
								matched = 1'b1;
							end
						end
					end
					default: begin
						if (scan_ph == tts_pkg::PH_CLOSE1 && b == tts_pkg::BRACE_CLOSE) begin
							hit = 1'b1;
							rep.text_start = tts_pkg::FIELD_BITS'(run_from);
							rep.tag_start = tts_pkg::FIELD_BITS'(brace_at);
							rep.tag_end = tts_pkg::FIELD_BITS'(cur);
							rep.tag_kind = held_kind;
							run_from = pos_step(cur);
							scan_ph = tts_pkg::PH_SEARCH;
						end else if (b == tts_pkg::CLOSE_MARK[held_kind]) begin
							scan_ph = tts_pkg::PH_CLOSE1;
						end else begin
							// not a closing mark: back inside the tag, the closing pair has failed
							scan_ph = tts_pkg::PH_INSIDE;
						end
					end
				endcase
			end
		end
		if (hit || last) begin
			rep.found = hit;
			rep.done_res = last;
			tag_reports_q.push_back(rep);
		end
		if (last)
			clear_scan_state();
	endtask

	// driver: one transaction per accepted byte, valid held until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			clear_scan_state();
		end else begin
			if (in_valid && text_in.ready)
				predict_scan(in_byte, in_last);
			if (!in_valid || text_in.ready) begin
				if (text_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_item = text_q.pop_front();
					in_byte <= next_item.text_byte;
					in_last <= next_item.last_byte;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (tag_out.valid && out_ready) begin
				if (tag_reports_q.size() == 0) begin
					$error("result transaction with no expectation waiting");
					errors++;
				end else begin
					got_report = tag_reports_q.pop_front();
					if (tag_out.found !== got_report.found) begin
						$error("found: expected %0d, got %0d", got_report.found, tag_out.found);
						errors++;
					end
					if (tag_out.done_res !== got_report.done_res) begin
						$error("done_res: expected %0d, got %0d", got_report.done_res,
							tag_out.done_res);
						errors++;
					end
					if (tag_out.text_start !== got_report.text_start) begin
						$error("text_start: expected %0d, got %0d", got_report.text_start,
							tag_out.text_start);
						errors++;
					end
					if (tag_out.tag_start !== got_report.tag_start) begin
						$error("tag_start: expected %0d, got %0d", got_report.tag_start,
							tag_out.tag_start);
						errors++;
					end
					if (tag_out.tag_end !== got_report.tag_end) begin
						$error("tag_end: expected %0d, got %0d", got_report.tag_end,
							tag_out.tag_end);
						errors++;
					end
					if (tag_out.tag_kind !== got_report.tag_kind) begin
						$error("tag_kind: expected %0d, got %0d", got_report.tag_kind,
							tag_out.tag_kind);
						errors++;
					end
				end
			end
			out_ready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// long receiver hold-off so the pipeline backs up into the input
	initial begin
		while (!hold_go)
			@(negedge clk);
		recv_hold = 1'b1;
		repeat (HOLD_OFF_CYCLES) @(negedge clk);
		recv_hold = 1'b0;
	end

	task automatic push_byte(input logic [7:0] b, input logic last);
		text_item_t it;
		it.text_byte = b;
		it.last_byte = last;
		text_q.push_back(it);
		phase_items++;
	endtask

	function automatic logic [7:0] plain_byte();
		int c;
		c = $urandom_range(0, 99);
		if (c < 8)
			return tts_pkg::BRACE_OPEN;
		else if (c < 16)
			return tts_pkg::BRACE_CLOSE;
		else if (c < 24)
			return tts_pkg::CLOSE_MARK[$urandom_range(0, tts_pkg::NUM_KINDS - 1)];
		return 8'($urandom_range(1, 255));
	endfunction

	// one text: well-formed tags with random content, runs of plain bytes, some broken sequences
	task automatic gen_text();
		int         nseg;
		int         c;
		int         k;
		int         n;
		text_item_t tail;
		nseg = $urandom_range(1, 5);
		for (int s = 0; s < nseg; s++) begin
			c = $urandom_range(0, 99);
			k = $urandom_range(0, tts_pkg::NUM_KINDS - 1);
			if (c < 30) begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					push_byte(plain_byte(), 1'b0);
			end else if (c < 75) begin
				push_byte(tts_pkg::BRACE_OPEN, 1'b0);
				push_byte(tts_pkg::OPEN_MARK[k], 1'b0);
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++)
					push_byte(plain_byte(), 1'b0);
				push_byte(tts_pkg::CLOSE_MARK[k], 1'b0);
				push_byte(tts_pkg::BRACE_CLOSE, 1'b0);
			end else if (c < 80) begin
				push_byte(tts_pkg::BRACE_OPEN, 1'b0);
				push_byte(plain_byte(), 1'b0);
			end else if (c < 86) begin
				push_byte(tts_pkg::BRACE_OPEN, 1'b0);
				push_byte(tts_pkg::OPEN_MARK[k], 1'b0);
				push_byte(tts_pkg::CLOSE_MARK[k], 1'b0);
				push_byte(plain_byte(), 1'b0);
				push_byte(tts_pkg::CLOSE_MARK[k], 1'b0);
				push_byte(tts_pkg::BRACE_CLOSE, 1'b0);
			end else if (c < 91) begin
				push_byte(tts_pkg::BRACE_OPEN, 1'b0);
				push_byte(tts_pkg::OPEN_MARK[k], 1'b0);
				n = $urandom_range(0, 5);
				for (int i = 0; i < n; i++)
					push_byte(plain_byte(), 1'b0);
			end else if (c < 96) begin
				push_byte(tts_pkg::CLOSE_MARK[k], 1'b0);
				push_byte(tts_pkg::BRACE_CLOSE, 1'b0);
			end else begin
				push_byte(tts_pkg::TERMINATOR, 1'b0);
			end
		end
		if ($urandom_range(0, 1) != 0) begin
			push_byte(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			tail = text_q.pop_back();
			tail.last_byte = 1'b1;
			text_q.push_back(tail);
		end
	endtask

	task automatic drain_all();
		while (text_q.size() != 0 || in_valid || tag_reports_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_phase(input int send_pct, input int recv_pct, input bit with_hold);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		phase_items = 0;
		while (phase_items < ITEMS_PER_PHASE)
			gen_text();
		if (with_hold)
			hold_go = 1'b1;
		drain_all();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// kind 1 with a failed closing pair, a brace with no mark, tag closed on the last byte
		push_byte("{", 1'b0);
		push_byte("_", 1'b0);
		push_byte("a", 1'b0);
		push_byte("_", 1'b0);
		push_byte("_", 1'b0);
		push_byte("}", 1'b0);
		push_byte("{", 1'b0);
		push_byte("x", 1'b0);
		push_byte("{", 1'b0);
		push_byte("(", 1'b0);
		push_byte(")", 1'b0);
		push_byte("}", 1'b1);
		// top byte, unclosed tag cut by a zero byte, ignored tag after the stop
		push_byte(8'hFF, 1'b0);
		push_byte("{", 1'b0);
		push_byte("<", 1'b0);
		push_byte(tts_pkg::TERMINATOR, 1'b0);
		push_byte("{", 1'b0);
		push_byte("{", 1'b0);
		push_byte("}", 1'b0);
		push_byte("}", 1'b1);
		// text of one byte, an opening brace
		push_byte("{", 1'b1);
		drain_all();

		random_phase(0, 0, 1'b1);
		random_phase(45, 0, 1'b0);
		random_phase(0, 45, 1'b0);
		random_phase(10, 10, 1'b0);

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
